### sv/isort_pkg.sv
package isort_pkg;

   localparam int unsigned VALUE_WIDTH = 32;

   // Contents of one cell as seen by its neighbors
   typedef struct packed {
      logic                          valid;
      logic signed [VALUE_WIDTH-1:0] value;
   } isort_link_type;

   // Sorter control states
   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } isort_state_type;

endpackage

### sv/isort_cell.sv
module isort_cell (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         insert,
   input  logic                                         emit,
   input  logic signed [isort_pkg::VALUE_WIDTH-1:0]     new_value,
   input  isort_pkg::isort_link_type                    left_link,
   input  logic                                         left_gt,
   input  isort_pkg::isort_link_type                    right_link,
   output isort_pkg::isort_link_type                    own_link,
   output logic                                         own_gt
);
   import isort_pkg::*;

   logic                          valid_ff;
   logic                          valid_in;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;

   // An empty cell counts as greater than anything, so it sits in the shift zone
   assign own_gt = !valid_ff || (value_ff > new_value);

   assign own_link.valid = valid_ff;
   assign own_link.value = value_ff;

   // Emission shifts toward cell 0; insertion shifts the greater tail away from it
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (emit) begin
         valid_in = right_link.valid;
         value_in = right_link.value;
      end else if (insert && own_gt) begin
         valid_in = valid_ff | left_link.valid;
         value_in = left_gt ? left_link.value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### sv/insertion_sorter.sv
// Streaming insertion sorter. While loading, one value is taken per clock
// (start high, busy low) and placed into a chain of MAX_ELEMENTS compare
// cells in that same cycle; equal values keep arrival order. The transaction
// with req_last_in set is stored too, then busy goes high and the set comes
// out in ascending order on rsp_*, one result per cycle with rsp_strobe
// high, since the chain shifts one cell toward the output each cycle; a set
// holds 1 to MAX_ELEMENTS values. The result with rsp_last_out high is the
// greatest value; busy drops in the cycle after it. The receiver cannot
// stall: every result is shown for exactly one cycle. Values arriving once
// the chain is full are dropped and rsp_overflow is high on every result
// of that set.
module insertion_sorter #(
   parameter int unsigned MAX_ELEMENTS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [isort_pkg::VALUE_WIDTH-1:0] req_sample_value,
   input  logic                                     req_last_in,
   output logic                                     rsp_strobe,
   output logic signed [isort_pkg::VALUE_WIDTH-1:0] rsp_sorted_value,
   output logic                                     rsp_last_out,
   output logic                                     rsp_overflow
);
   import isort_pkg::*;

   isort_state_type state_ff;
   isort_state_type state_in;
   logic            dropped_ff;
   logic            dropped_in;

   isort_link_type  links [MAX_ELEMENTS];
   logic            gts   [MAX_ELEMENTS];

   logic            accept;
   logic            full;
   logic            insert;
   logic            emit;

   assign busy   = (state_ff == ST_EMIT);
   assign accept = start && !busy;
   assign full   = links[MAX_ELEMENTS-1].valid;
   assign insert = accept && !full;
   assign emit   = (state_ff == ST_EMIT);

   // Cell chain
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      isort_link_type left_link;
      isort_link_type right_link;
      logic           left_gt;

      if (i == 0) begin : g_head
         assign left_link.valid = 1'b1;
         assign left_link.value = req_sample_value;
         assign left_gt         = 1'b0;
      end else begin : g_body
         assign left_link = links[i-1];
         assign left_gt   = gts[i-1];
      end

      if (i == MAX_ELEMENTS - 1) begin : g_tail
         assign right_link.valid = 1'b0;
         assign right_link.value = req_sample_value;
      end else begin : g_inner
         assign right_link = links[i+1];
      end

      isort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .insert     (insert),
         .emit       (emit),
         .new_value  (req_sample_value),
         .left_link  (left_link),
         .left_gt    (left_gt),
         .right_link (right_link),
         .own_link   (links[i]),
         .own_gt     (gts[i])
      );
   end

   // Result port: cell 0 is always the smallest remaining value
   assign rsp_strobe       = emit;
   assign rsp_sorted_value = links[0].value;
   assign rsp_last_out     = emit && !links[1].valid;
   assign rsp_overflow     = dropped_ff;

   // Control
   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && full) begin
               dropped_in = 1'b1;
            end
            if (accept && req_last_in) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_last_out) begin
               state_in   = ST_LOAD;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in   = ST_LOAD;
            dropped_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule
